// ===== rtl/mda_pkg.sv =====
// Shared constants and types of the motion derivative averager.
`default_nettype none
package mda_pkg;
  localparam int DATA_W    = 32;
  localparam int WIN_W     = 11;
  localparam int THR_W     = 26;
  localparam int CFG_IDX_W = 2;
  localparam int NDER      = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VEL_THR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACC_THR = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_JRK_THR = 2'd3;

  localparam logic [1:0] DER_VEL = 2'd0;
  localparam logic [1:0] DER_ACC = 2'd1;
  localparam logic [1:0] DER_JRK = 2'd2;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic upd_item;
    logic upd_acc;
    logic sum_clr;
  } ring_ctl_t;
endpackage
`default_nettype wire

// ===== rtl/mda_ifs.sv =====
// Request channels of the motion derivative averager.
`default_nettype none
interface mda_in_if;
  logic                       valid;
  logic                       ready;
  logic signed [31:0]         position;
  modport source (output valid, output position, input ready);
  modport sink   (input valid, input position, output ready);
endinterface

interface mda_out_if;
  logic                       valid;
  logic                       ready;
  logic signed [31:0]         velocity_mean;
  logic                       velocity_trigger;
  logic signed [31:0]         acceleration_mean;
  logic                       acceleration_trigger;
  logic signed [31:0]         jerk_mean;
  logic                       jerk_trigger;
  modport source (output valid, output velocity_mean, output velocity_trigger,
                  output acceleration_mean, output acceleration_trigger,
                  output jerk_mean, output jerk_trigger, input ready);
  modport sink   (input valid, input velocity_mean, input velocity_trigger,
                  input acceleration_mean, input acceleration_trigger,
                  input jerk_mean, input jerk_trigger, output ready);
endinterface
`default_nettype wire

// ===== rtl/mda_ring.sv =====
// Sample ring memory with running window sum.
`default_nettype none
module mda_ring #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int SUM_W = 43
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire mda_pkg::ring_ctl_t        ctl_i,
  input  wire logic [AW-1:0]             addr_i,
  input  wire logic [mda_pkg::DATA_W-1:0] wr_data_i,
  output logic signed [SUM_W-1:0]        sum_o
);
  logic [mda_pkg::DATA_W-1:0] mem_q [DEPTH];
  logic [mda_pkg::DATA_W-1:0] rd_q;
  logic signed [SUM_W-1:0]    sum_q, sum_d;
  logic signed [SUM_W-1:0]    new_ext, old_ext;

  assign new_ext = SUM_W'(signed'(wr_data_i));
  assign old_ext = SUM_W'(signed'(rd_q));

  always_comb begin
    sum_d = sum_q;
    if (ctl_i.sum_clr) begin
      sum_d = '0;
    end else if (ctl_i.upd_item) begin
      // replace the old slot value by the new one
      sum_d = sum_q + new_ext - old_ext;
    end else if (ctl_i.upd_acc) begin
      sum_d = sum_q + old_ext;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[addr_i] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_q <= mem_q[addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;
endmodule
`default_nettype wire

// ===== rtl/mda_div.sv =====
// Bit-serial signed divider of a window sum by the window size.
`default_nettype none
module mda_div #(
  parameter int SUM_W = 43
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic signed [SUM_W-1:0]      dividend_i,
  input  wire logic [mda_pkg::WIN_W-1:0]    divisor_i,
  output logic                              done_o,
  output logic signed [mda_pkg::DATA_W-1:0] quot_o
);
  localparam int DCW = $clog2(SUM_W);
  localparam int WW  = mda_pkg::WIN_W;

  logic [SUM_W-1:0] dvd_q;
  logic [WW-1:0]    rem_q;
  logic [WW-1:0]    div_q;
  logic             neg_q, busy_q, done_q;
  logic [DCW-1:0]   cnt_q;
  logic [WW:0]      rem_sh, rem_sub;
  logic             ge;
  logic [SUM_W-1:0] mag;

  assign mag     = dividend_i[SUM_W-1] ? SUM_W'(-dividend_i) : SUM_W'(dividend_i);
  assign rem_sh  = {rem_q, dvd_q[SUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, div_q};
  assign ge      = rem_sh >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DCW'(SUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= mag;
      rem_q <= '0;
      div_q <= divisor_i;
      neg_q <= dividend_i[SUM_W-1];
    end else if (busy_q) begin
      // one quotient bit a cycle, shifted in behind the dividend
      rem_q <= ge ? rem_sub[WW-1:0] : rem_sh[WW-1:0];
      dvd_q <= {dvd_q[SUM_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? -signed'(dvd_q[mda_pkg::DATA_W-1:0])
                        : signed'(dvd_q[mda_pkg::DATA_W-1:0]);
endmodule
`default_nettype wire

// ===== rtl/motion_derivative_averager.sv =====
// Top level of the motion derivative averager.
//
//   channel  | dir | handshake    | payload
//   in_i     | in  | valid/ready  | position
//   out_o    | out | valid/ready  | three means, three triggers
//   cfg      | in  | cfg_we_i     | cfg_idx_i, cfg_data_i
//
// Divide: the bit-serial divider is shared by the three means, which use it in turn.
// Reset: a clearing pass over all MAX_WINDOW slots zeroes the three rings; no request
//   is taken meanwhile. A window_size write starts a resum pass that rebuilds the
//   running sums.
// Stalls: the result sits in an output register; the next request is taken while
//   it waits, and a finished request holds until that register drains.
`default_nettype none
module motion_derivative_averager #(
  parameter int MAX_WINDOW = 1024
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  mda_in_if.sink                                 in_i,
  mda_out_if.source                              out_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [mda_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [mda_pkg::THR_W-1:0]         cfg_data_i
);
  localparam int AW    = $clog2(MAX_WINDOW);
  localparam int CW    = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = mda_pkg::DATA_W + AW + 1;
  localparam int DW    = mda_pkg::DATA_W;
  localparam int WW    = mda_pkg::WIN_W;
  localparam int TW    = mda_pkg::THR_W;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_UPD, S_DIVST, S_DIV, S_OUT, S_RSCLR, S_RS, S_RSLAST
  } state_e;

  state_e                 state_q;
  logic [1:0]             stage_q;
  logic [CW-1:0]          cnt_q;
  logic [AW-1:0]          slot_q;
  logic [WW-1:0]          win_q;
  logic [TW-1:0]          thr_q [mda_pkg::NDER];
  logic signed [DW-1:0]   pos_q, last_pos_q, last_vm_q, last_am_q;
  logic signed [DW-1:0]   mean_q [mda_pkg::NDER];
  logic [2:0]             trig_q, latch_q;
  logic [DW-1:0]          diff_q;
  logic                   out_valid_q;
  logic signed [DW-1:0]   out_vm_q, out_am_q, out_jm_q;
  logic [2:0]             out_trig_q;

  mda_pkg::ring_ctl_t     ctl [mda_pkg::NDER];
  logic signed [SUM_W-1:0] sum [mda_pkg::NDER];
  logic [AW-1:0]          addr;
  logic [DW-1:0]          wr_data;
  logic signed [DW-1:0]   diff_a, diff_b;
  logic signed [DW:0]     diff_full;
  logic [DW-1:0]          diff_sat;
  logic signed [SUM_W-1:0] dvd;
  logic                   div_start, div_done;
  logic signed [DW-1:0]   quot;
  logic [DW:0]            mag, thr_ext;
  logic                   gt, lt, pulse;
  logic [CW-1:0]          win_m1;
  logic                   win_ok;
  logic                   in_fire;
  logic                   win_wr;
  logic                   out_load;

  assign win_m1  = CW'(win_q) - CW'(1);
  assign win_ok  = (cfg_data_i[WW-1:0] != '0) && (32'(cfg_data_i[WW-1:0]) <= MAX_WINDOW);
  assign win_wr  = cfg_we_i && (cfg_idx_i == mda_pkg::CFG_WINDOW) && win_ok;
  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire = in_i.valid && in_i.ready;
  // Load the output register once the finished request finds it free.
  assign out_load = (state_q == S_OUT) && (!out_valid_q || out_o.ready);

  // Ring controls: addresses sweep during clear and resum passes, else the slot.
  always_comb begin
    for (int r = 0; r < mda_pkg::NDER; r++) begin
      ctl[r] = '0;
    end
    addr    = slot_q;
    wr_data = diff_q;
    case (state_q)
      S_CLEAR: begin
        addr    = cnt_q[AW-1:0];
        wr_data = '0;
        for (int r = 0; r < mda_pkg::NDER; r++) ctl[r].wr_en = 1'b1;
      end
      S_READ: begin
        ctl[stage_q].rd_en = 1'b1;
      end
      S_UPD: begin
        ctl[stage_q].wr_en    = 1'b1;
        ctl[stage_q].upd_item = 1'b1;
      end
      S_RSCLR: begin
        for (int r = 0; r < mda_pkg::NDER; r++) ctl[r].sum_clr = 1'b1;
      end
      S_RS: begin
        addr = cnt_q[AW-1:0];
        for (int r = 0; r < mda_pkg::NDER; r++) begin
          ctl[r].rd_en   = 1'b1;
          ctl[r].upd_acc = (cnt_q != '0);
        end
      end
      S_RSLAST: begin
        for (int r = 0; r < mda_pkg::NDER; r++) ctl[r].upd_acc = 1'b1;
      end
      default: ;
    endcase
  end

  for (genvar g = 0; g < mda_pkg::NDER; g++) begin : g_ring
    mda_ring #(.DEPTH(MAX_WINDOW), .AW(AW), .SUM_W(SUM_W)) u_ring (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (ctl[g]),
      .addr_i   (addr),
      .wr_data_i(wr_data),
      .sum_o    (sum[g])
    );
  end

  // Difference for the current derivative, saturated to 32 bits.
  always_comb begin
    case (stage_q)
      mda_pkg::DER_VEL: begin diff_a = pos_q;     diff_b = last_pos_q; end
      mda_pkg::DER_ACC: begin diff_a = mean_q[0]; diff_b = last_vm_q;  end
      default:          begin diff_a = mean_q[1]; diff_b = last_am_q;  end
    endcase
    diff_full = (DW+1)'(diff_a) - (DW+1)'(diff_b);
    if (diff_full[DW] != diff_full[DW-1]) begin
      diff_sat = diff_full[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      diff_sat = diff_full[DW-1:0];
    end
  end

  assign div_start = (state_q == S_DIVST);
  assign dvd       = sum[stage_q];

  mda_div #(.SUM_W(SUM_W)) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(dvd),
    .divisor_i (win_q),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  // Trigger: true magnitude against the threshold, with a latch per derivative.
  assign mag     = quot[DW-1] ? ((DW+1)'(0) - {1'b1, quot}) : {1'b0, quot};
  assign thr_ext = (DW+1)'(thr_q[stage_q]);
  assign gt      = mag > thr_ext;
  assign lt      = mag < thr_ext;
  assign pulse   = gt && !latch_q[stage_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      stage_q     <= mda_pkg::DER_VEL;
      cnt_q       <= '0;
      slot_q      <= '0;
      win_q       <= WW'(1);
      thr_q[0]    <= TW'(65536);
      thr_q[1]    <= TW'(65536);
      thr_q[2]    <= TW'(65536);
      last_pos_q  <= '0;
      last_vm_q   <= '0;
      last_am_q   <= '0;
      latch_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // refill on a finished request, else drop the result once it is taken
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      // a window write takes over the sequencing, except during the clearing pass
      if (!win_wr || state_q == S_CLEAR) begin
        case (state_q)
          S_CLEAR: begin
            cnt_q <= cnt_q + 1'b1;
            if (cnt_q == CW'(MAX_WINDOW - 1)) begin
              state_q <= S_IDLE;
            end
          end
          S_IDLE: begin
            if (in_fire) begin
              stage_q <= mda_pkg::DER_VEL;
              state_q <= S_READ;
            end
          end
          S_READ:  state_q <= S_UPD;
          S_UPD:   state_q <= S_DIVST;
          S_DIVST: state_q <= S_DIV;
          S_DIV: begin
            if (div_done) begin
              if (lt) begin
                latch_q[stage_q] <= 1'b0;
              end else if (pulse) begin
                latch_q[stage_q] <= 1'b1;
              end
              if (stage_q == mda_pkg::DER_JRK) begin
                state_q <= S_OUT;
              end else begin
                stage_q <= stage_q + 1'b1;
                state_q <= S_READ;
              end
            end
          end
          S_OUT: begin
            // hold until the output register is free
            if (out_load) begin
              last_pos_q  <= pos_q;
              last_vm_q   <= mean_q[0];
              last_am_q   <= mean_q[1];
              slot_q      <= (CW'(slot_q) + CW'(1) == CW'(win_q)) ? '0 : slot_q + 1'b1;
              state_q     <= S_IDLE;
            end
          end
          S_RSCLR: begin
            cnt_q   <= '0;
            state_q <= S_RS;
          end
          S_RS: begin
            if (cnt_q == win_m1) begin
              state_q <= S_RSLAST;
            end else begin
              cnt_q <= cnt_q + 1'b1;
            end
          end
          S_RSLAST: state_q <= S_IDLE;
          default:  state_q <= S_IDLE;
        endcase
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          mda_pkg::CFG_WINDOW: begin
            if (win_ok) begin
              win_q  <= cfg_data_i[WW-1:0];
              slot_q <= '0;
              // rings already zero during the clearing pass
              if (state_q != S_CLEAR) begin
                state_q <= S_RSCLR;
              end
            end
          end
          mda_pkg::CFG_VEL_THR: thr_q[0] <= cfg_data_i;
          mda_pkg::CFG_ACC_THR: thr_q[1] <= cfg_data_i;
          mda_pkg::CFG_JRK_THR: thr_q[2] <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pos_q <= in_i.position;
    end
    if (state_q == S_READ) begin
      diff_q <= diff_sat;
    end
    if (state_q == S_DIV && div_done) begin
      mean_q[stage_q] <= quot;
      trig_q[stage_q] <= pulse;
    end
    if (out_load) begin
      out_vm_q   <= mean_q[0];
      out_am_q   <= mean_q[1];
      out_jm_q   <= mean_q[2];
      out_trig_q <= trig_q;
    end
  end

  assign out_o.valid                = out_valid_q;
  assign out_o.velocity_mean        = out_vm_q;
  assign out_o.velocity_trigger     = out_trig_q[0];
  assign out_o.acceleration_mean    = out_am_q;
  assign out_o.acceleration_trigger = out_trig_q[1];
  assign out_o.jerk_mean            = out_jm_q;
  assign out_o.jerk_trigger         = out_trig_q[2];

`ifndef ASSERT_OFF
  a_slot_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW'(slot_q) < CW'(win_q))
    else $error("slot pointer beyond window");
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider finished outside divide state");
  a_upd_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_UPD |-> $past(state_q) == S_READ)
    else $error("ring update without prior read");
  a_trig_above_thr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && div_done && pulse) |-> gt && !lt)
    else $error("trigger without magnitude above threshold");
`endif
endmodule
`default_nettype wire
